FILE: hw/rtl/linear_interp_resampler_core_defines.svh
// Assertion helpers used by the resampler back part.
`ifndef LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge of aclk outside reset.
`define LIR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge of aclk outside reset.
`define LIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lir_pkg.sv
package lir_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 18;
    localparam int PHASE_W  = 19;
    // Wide enough for (a << 16) plus a 17 x 17 bit product.
    localparam int ACC_W    = 35;

    // Defaults for the top-level parameters.
    localparam int DEF_FRAC_BITS = 12;
    localparam int DEF_MAX_RUN   = 64;

    // Queue between the front and back parts.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_STEP_SIZE       = 2'd0;
    localparam logic [1:0] REG_SOURCE_FORMAT   = 2'd1;
    localparam logic [1:0] REG_SOURCE_CHANNELS = 2'd2;
    localparam logic [1:0] REG_DEST_CHANNELS   = 2'd3;

    // Encodings.
    localparam logic       FMT_U8     = 1'b0;
    localparam logic [1:0] CH_MONO    = 2'd1;
    localparam logic [1:0] CH_STEREO  = 2'd2;

    // Reset values of the registers.
    localparam logic [STEP_W-1:0] RST_STEP_SIZE       = 18'd4096;
    localparam logic              RST_SOURCE_FORMAT   = 1'b1;
    localparam logic [1:0]        RST_SOURCE_CHANNELS = 2'd2;
    localparam logic [1:0]        RST_DEST_CHANNELS   = 2'd2;

    typedef struct packed {
        logic [STEP_W-1:0] step_size;
        logic              source_format;
        logic [1:0]        source_channels;
        logic [1:0]        dest_channels;
    } cfg_t;

    // One decoded frame as it waits in the queue.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       mono_dst;
    } frame_t;

    // Handshake between the queue and its neighbours.
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EMIT
    } back_state_t;

endpackage

FILE: hw/rtl/lir_front.sv
// Front part: takes source words, decodes them to signed 16 bit and applies
// the channel mapping before they enter the queue.
module lir_front (
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [31:0]                                s_tdata,
    input  lir_pkg::cfg_t                              cfg,
    input  logic                                       q_full,
    output logic                                       push,
    output lir_pkg::frame_t                            frame
);

    logic signed [lir_pkg::SAMPLE_W-1:0] dec_l;
    logic signed [lir_pkg::SAMPLE_W-1:0] dec_r;
    logic signed [lir_pkg::SAMPLE_W-1:0] src_r;
    logic signed [lir_pkg::SAMPLE_W:0]   sum_lr;
    logic                                mono_dst;

    // Sample decode: u8 becomes (x - 128) * 256, which is the top bit
    // inverted and shifted up by a byte.
    always_comb begin
        if (cfg.source_format == lir_pkg::FMT_U8) begin
            dec_l = {~s_tdata[7], s_tdata[6:0], 8'h00};
            dec_r = {~s_tdata[23], s_tdata[22:16], 8'h00};
        end else begin
            dec_l = s_tdata[15:0];
            dec_r = s_tdata[31:16];
        end
    end

    // Channel mapping: mono source duplicates left, mono destination takes
    // the floor of the average.
    always_comb begin
        mono_dst = (cfg.dest_channels == lir_pkg::CH_MONO);
        src_r    = (cfg.source_channels == lir_pkg::CH_STEREO) ? dec_r : dec_l;
        sum_lr   = {dec_l[lir_pkg::SAMPLE_W-1], dec_l} + {src_r[lir_pkg::SAMPLE_W-1], src_r};
        if (mono_dst) begin
            frame.left  = sum_lr[lir_pkg::SAMPLE_W:1];
            frame.right = sum_lr[lir_pkg::SAMPLE_W:1];
        end else begin
            frame.left  = dec_l;
            frame.right = src_r;
        end
        frame.mono_dst = mono_dst;
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

endmodule

FILE: hw/rtl/lir_queue.sv
// Short queue of decoded frames between the front and back parts.
module lir_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  lir_pkg::q_ctrl_t  ctrl,
    input  lir_pkg::frame_t   wr_frame,
    output lir_pkg::q_stat_t  stat,
    output lir_pkg::frame_t   rd_frame
);

    lir_pkg::frame_t              mem [lir_pkg::Q_DEPTH];
    logic [lir_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [lir_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [lir_pkg::Q_CNT_W-1:0]  cnt_reg;
    logic [lir_pkg::Q_PTR_W-1:0]  wr_ptr_next;
    logic [lir_pkg::Q_PTR_W-1:0]  rd_ptr_next;
    logic [lir_pkg::Q_CNT_W-1:0]  cnt_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (ctrl.push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (ctrl.pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!ctrl.push && ctrl.pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Frame storage.
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[wr_ptr_reg] <= wr_frame;
        end
    end

    assign rd_frame       = mem[rd_ptr_reg];
    assign stat.full      = (cnt_reg == lir_pkg::Q_CNT_W'(lir_pkg::Q_DEPTH));
    assign stat.not_empty = (cnt_reg != '0);

endmodule

FILE: hw/rtl/lir_back.sv
`include "linear_interp_resampler_core_defines.svh"

// Back part: holds the previous frame and the phase, and runs the
// interpolation for the frame at the head of the queue, making each output word
// by a multiply, then an add and shift into the output register once it is free.
module lir_back #(
    parameter int FRAC_BITS = lir_pkg::DEF_FRAC_BITS,
    parameter int MAX_RUN   = lir_pkg::DEF_MAX_RUN
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lir_pkg::STEP_W-1:0]    step_size,
    input  logic                          q_valid,
    input  lir_pkg::frame_t               q_frame,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic                          m_tlast
);

    localparam int PW    = lir_pkg::PHASE_W;
    localparam int SW    = lir_pkg::SAMPLE_W;
    localparam int AW    = lir_pkg::ACC_W;
    localparam int PRODW = 2 * (SW + 1);
    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam logic [PW-1:0] ONE = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;

    lir_pkg::back_state_t      state_reg, state_next;
    logic [PW-1:0]             phase_reg, phase_next;
    logic signed [SW-1:0]      prev_l_reg, prev_l_next;
    logic signed [SW-1:0]      prev_r_reg, prev_r_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_last_reg, m_last_next;
    logic signed [SW-1:0]      out_l_reg, out_l_next;
    logic signed [SW-1:0]      out_r_reg, out_r_next;
    logic signed [PRODW-1:0]   prod_l_reg, prod_l_next;
    logic signed [PRODW-1:0]   prod_r_reg, prod_r_next;

    logic [PW-1:0]             phase_adv;
    logic [PW-1:0]             phase_end;
    logic                      run_done;
    logic                      out_free;
    logic signed [SW:0]        diff_l;
    logic signed [SW:0]        diff_r;
    logic signed [SW:0]        frac;
    logic signed [AW-1:0]      acc_l;
    logic signed [AW-1:0]      acc_r;

    // Run control: the phase after this output and whether the run ends.
    always_comb begin
        phase_adv = phase_reg + {1'b0, step_size};
        run_done  = (phase_adv >= ONE) || (cnt_reg == CNT_W'(MAX_RUN - 1));
        phase_end = (phase_adv >= ONE) ? (phase_adv - ONE) : '0;
        out_free  = !m_valid_reg || m_tready;
    end

    // Interpolation as a + (b - a) * p, then a floor shift by FRAC_BITS.
    always_comb begin
        diff_l = {q_frame.left[SW-1], q_frame.left} - {prev_l_reg[SW-1], prev_l_reg};
        diff_r = {q_frame.right[SW-1], q_frame.right} - {prev_r_reg[SW-1], prev_r_reg};
        frac   = {1'b0, phase_reg[SW-1:0]};
        acc_l  = ({{(AW-SW){prev_l_reg[SW-1]}}, prev_l_reg} <<< FRAC_BITS)
                 + {{(AW-PRODW){prod_l_reg[PRODW-1]}}, prod_l_reg};
        acc_r  = ({{(AW-SW){prev_r_reg[SW-1]}}, prev_r_reg} <<< FRAC_BITS)
                 + {{(AW-PRODW){prod_r_reg[PRODW-1]}}, prod_r_reg};
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lir_pkg::ST_IDLE: begin
                if (q_valid && (phase_reg < ONE)) begin
                    state_next = lir_pkg::ST_MUL;
                end
            end
            lir_pkg::ST_MUL: begin
                state_next = lir_pkg::ST_EMIT;
            end
            lir_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = run_done ? lir_pkg::ST_IDLE : lir_pkg::ST_MUL;
                end
            end
            default: begin
                state_next = lir_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        phase_next   = phase_reg;
        prev_l_next  = prev_l_reg;
        prev_r_next  = prev_r_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_last_next  = m_last_reg;
        out_l_next   = out_l_reg;
        out_r_next   = out_r_reg;
        prod_l_next  = prod_l_reg;
        prod_r_next  = prod_r_reg;
        pop          = 1'b0;
        case (state_reg)
            lir_pkg::ST_IDLE: begin
                // A frame that produces no output moves the phase on and becomes the previous frame.
                if (q_valid && (phase_reg >= ONE)) begin
                    pop         = 1'b1;
                    phase_next  = phase_reg - ONE;
                    prev_l_next = q_frame.left;
                    prev_r_next = q_frame.right;
                    cnt_next    = '0;
                end
            end
            lir_pkg::ST_MUL: begin
                prod_l_next = diff_l * frac;
                prod_r_next = diff_r * frac;
            end
            lir_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = run_done;
                    out_l_next   = acc_l[FRAC_BITS +: SW];
                    out_r_next   = q_frame.mono_dst ? '0 : acc_r[FRAC_BITS +: SW];
                    if (run_done) begin
                        pop         = 1'b1;
                        phase_next  = phase_end;
                        prev_l_next = q_frame.left;
                        prev_r_next = q_frame.right;
                        cnt_next    = '0;
                    end else begin
                        phase_next = phase_adv;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    // Control state, phase, previous frame, run count and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lir_pkg::ST_IDLE;
            phase_reg   <= ONE;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            prev_l_reg  <= prev_l_next;
            prev_r_reg  <= prev_r_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Products and output word.
    always_ff @(posedge aclk) begin
        prod_l_reg <= prod_l_next;
        prod_r_reg <= prod_r_next;
        out_l_reg  <= out_l_next;
        out_r_reg  <= out_r_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_r_reg, out_l_reg};
    assign m_tlast  = m_last_reg;

    `LIR_ASSERT_IMPLIES(a_run_phase_below_one, (state_reg != lir_pkg::ST_IDLE), (phase_reg < ONE), "run active with phase at or above one")
    `LIR_ASSERT_IMPLIES(a_pop_needs_frame, pop, q_valid, "queue popped while empty")
    `LIR_ASSERT_IMPLIES(a_run_count_bound, 1'b1, (cnt_reg <= CNT_W'(MAX_RUN - 1)), "run count past limit")
    `LIR_ASSERT_NEXT(a_pop_returns_idle, pop, (state_reg == lir_pkg::ST_IDLE), "frame retired without returning to idle")

endmodule

FILE: hw/rtl/linear_interp_resampler_core.sv
// Each output word is made after its frame reaches the head of the queue: a multiply,
// then an add and shift into the output register once that register is free;
// a frame that gives no output leaves the queue from idle with no multiply.
// Input is taken while the 2-entry frame queue has room, so it overlaps the run.
// Reset (aresetn low, synchronous): registers return to their defaults, phase is
// one whole frame, previous frame is zero, queue and output register are empty.
module linear_interp_resampler_core #(
    parameter int FRAC_BITS = lir_pkg::DEF_FRAC_BITS,
    parameter int MAX_RUN   = lir_pkg::DEF_MAX_RUN
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] sample_left, [31:16] sample_right
    // Output words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] out_left, [31:16] out_right
    output logic        m_tlast,    // last_of_run
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lir_pkg::cfg_t     cfg_reg, cfg_next;
    lir_pkg::q_ctrl_t  q_ctrl;
    lir_pkg::q_stat_t  q_stat;
    lir_pkg::frame_t   wr_frame;
    lir_pkg::frame_t   rd_frame;
    logic              cfg_wr;
    logic              q_push;
    logic              q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Queue control gathered from the front and back parts.
    assign q_ctrl = '{push: q_push, pop: q_pop};

    // Register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (paddr[3:2])
                lir_pkg::REG_STEP_SIZE:       cfg_next.step_size       = pwdata[lir_pkg::STEP_W-1:0];
                lir_pkg::REG_SOURCE_FORMAT:   cfg_next.source_format   = pwdata[0];
                lir_pkg::REG_SOURCE_CHANNELS: cfg_next.source_channels = pwdata[1:0];
                lir_pkg::REG_DEST_CHANNELS:   cfg_next.dest_channels   = pwdata[1:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_size       <= lir_pkg::RST_STEP_SIZE;
            cfg_reg.source_format   <= lir_pkg::RST_SOURCE_FORMAT;
            cfg_reg.source_channels <= lir_pkg::RST_SOURCE_CHANNELS;
            cfg_reg.dest_channels   <= lir_pkg::RST_DEST_CHANNELS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Register reads.
    always_comb begin
        case (paddr[3:2])
            lir_pkg::REG_STEP_SIZE:       prdata = 32'(cfg_reg.step_size);
            lir_pkg::REG_SOURCE_FORMAT:   prdata = 32'(cfg_reg.source_format);
            lir_pkg::REG_SOURCE_CHANNELS: prdata = 32'(cfg_reg.source_channels);
            lir_pkg::REG_DEST_CHANNELS:   prdata = 32'(cfg_reg.dest_channels);
            default:                      prdata = '0;
        endcase
    end

    lir_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .q_full   (q_stat.full),
        .push     (q_push),
        .frame    (wr_frame)
    );

    lir_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (q_ctrl),
        .wr_frame (wr_frame),
        .stat     (q_stat),
        .rd_frame (rd_frame)
    );

    lir_back #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_RUN   (MAX_RUN)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_size (cfg_reg.step_size),
        .q_valid   (q_stat.not_empty),
        .q_frame   (rd_frame),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
